[rtl/pmc_pkg.sv]
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared types and constants of the pointer motion conditioner.
// ----------------------------------------------------------------------------
package pmc_pkg;

  // Elapsed time floor and wheel scale
  localparam logic [31:0]        MIN_GAP_US   = 32'd1000;
  localparam logic signed [15:0] SCROLL_SCALE = 16'sd120;

  // Datapath widths
  localparam int GAIN_W     = 26;  // unsigned Q16.10 gain after slowdown
  localparam int DIVIDEND_W = 57;  // magnitude of the smoothing numerator
  localparam int DIVISOR_W  = 33;  // prev_gap + gap
  localparam int QUO_W      = 26;  // quotient bits produced by the divider
  localparam int MOT_W      = 25;  // signed Q.8 motion
  localparam int DIV_STEPS  = 26;  // one quotient bit per cycle
  localparam int DIV_CNT_W  = 5;

  // Register indexes of the configuration port
  typedef enum logic [3:0] {
    REG_SENSITIVITY = 4'd0,
    REG_ACCEL       = 4'd1,
    REG_PRECISION   = 4'd2,
    REG_PREC_DIV    = 4'd3,
    REG_QUIET_THR   = 4'd4,
    REG_QUIET_TMO   = 4'd5,
    REG_INVERT_Y    = 4'd6,
    REG_FILTER      = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] sensitivity;
    logic        accel_enable;
    logic        precision_enable;
    logic [15:0] precision_divisor;
    logic [15:0] quiet_threshold;
    logic [15:0] quiet_timeout;
    logic        invert_y;
    logic        filter_enable;
  } cfg_t;

  // Which operand pair feeds the shared divider
  typedef enum logic [1:0] {
    DSEL_GAIN = 2'd0,
    DSEL_X    = 2'd1,
    DSEL_Y    = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     calc1;
    logic     calc2;
    logic     calc3;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_capture;
    logic     mult;
    logic     fin_load;
  } dp_cmd_t;

  typedef struct packed {
    logic slow;
    logic filter;
    logic div_busy;
  } dp_stat_t;

endpackage

[rtl/pmc_div.sv]
// ----------------------------------------------------------------------------
// pmc_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// The upper dividend bits preload the remainder; the caller guarantees that
// they are below the divisor, so QUO_W steps give the whole quotient.
// ----------------------------------------------------------------------------
module pmc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pmc_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [pmc_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           busy,
  output logic [pmc_pkg::QUO_W-1:0]      quotient
);
  import pmc_pkg::*;

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [QUO_W-1:0]     shreg;
  logic [DIV_CNT_W-1:0] cnt;

  logic [DIVISOR_W:0]   trial;
  logic                 ge;

  // One trial subtraction
  assign trial = {rem, shreg[QUO_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUO_W]);
      shreg <= dividend[QUO_W-1:0];
      dsr   <= divisor;
    end else if (busy) begin
      rem   <= ge ? DIVISOR_W'(trial - {1'b0, dsr}) : trial[DIVISOR_W-1:0];
      shreg <= {shreg[QUO_W-2:0], ge};
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  assign busy     = cnt != '0;
  assign quotient = shreg;

endmodule

[rtl/pmc_datapath.sv]
// ----------------------------------------------------------------------------
// pmc_datapath
// Gain, quiet counting, smoothing numerators, output scaling and saturation.
// Steps are driven by the command struct from the controller.
// ----------------------------------------------------------------------------
module pmc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pmc_pkg::cfg_t       cfg,
  input  pmc_pkg::dp_cmd_t    cmd,
  output pmc_pkg::dp_stat_t   stat,
  input  logic signed [15:0]  move_x,
  input  logic signed [15:0]  move_y,
  input  logic signed [7:0]   wheel,
  input  logic [31:0]         stamp_us,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [15:0]  out_wheel
);
  import pmc_pkg::*;

  localparam logic [15:0]        QC_MAX  = 16'hFFFF;
  localparam logic signed [41:0] SAT_HI  = 42'sd2147483647;
  localparam logic signed [41:0] SAT_LO  = -42'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = 32'sh7fffffff;
    else if (v < SAT_LO) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Item registers
  logic signed [15:0] dx, dy;
  logic signed [7:0]  wh;
  logic [31:0]        stamp;

  // Persistent state
  logic [15:0]        quiet_count;
  logic [31:0]        last_stamp;
  logic signed [15:0] prev_x, prev_y;
  logic [31:0]        prev_gap;

  // Intermediate registers
  logic [31:0]             gap;
  logic [31:0]             sq_x, sq_y, thr2;
  logic [GAIN_W-1:0]       gain;
  logic signed [48:0]      px_x, cx_x, px_y, cx_y;
  logic [DIVISOR_W-1:0]    den;
  logic [DIVIDEND_W-1:0]   num_x, num_y;
  logic                    neg_x, neg_y;
  logic signed [MOT_W-1:0] mx, my;
  logic signed [51:0]      prod_x, prod_y;

  // Combinational helpers
  logic [31:0]             diff;
  logic signed [31:0]      sq_x_c, sq_y_c;
  logic [32:0]             mag2;
  logic                    quiet;
  logic signed [49:0]      sum_x, sum_y;
  logic [49:0]             abs_x, abs_y;
  logic [DIVIDEND_W-1:0]   div_dividend;
  logic [DIVISOR_W-1:0]    div_divisor;
  logic [QUO_W-1:0]        quo;
  logic signed [MOT_W-1:0] q_mot;
  logic signed [51:0]      rnd_x, rnd_y;
  logic signed [41:0]      p_x, p_y, p_y_dir;
  logic signed [15:0]      wh_ext;

  assign diff   = stamp - last_stamp;
  assign sq_x_c = dx * dx;
  assign sq_y_c = dy * dy;
  assign mag2   = {1'b0, sq_x} + {1'b0, sq_y};
  assign quiet  = mag2 < {1'b0, thr2};
  assign sum_x  = px_x + cx_x;
  assign sum_y  = px_y + cx_y;
  assign abs_x  = sum_x[49] ? 50'(-sum_x) : 50'(sum_x);
  assign abs_y  = sum_y[49] ? 50'(-sum_y) : 50'(sum_y);
  assign q_mot  = {1'b0, quo[MOT_W-2:0]};

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dx    <= move_x;
      dy    <= move_y;
      wh    <= wheel;
      stamp <= stamp_us;
    end
  end

  // Step 1: elapsed time, squares, base gain
  always_ff @(posedge clk) begin
    if (cmd.calc1) begin
      gap  <= (diff < MIN_GAP_US) ? MIN_GAP_US : diff;
      sq_x <= sq_x_c;
      sq_y <= sq_y_c;
      thr2 <= cfg.quiet_threshold * cfg.quiet_threshold;
    end
  end

  // Step 2: weighted products and smoothing denominator
  always_ff @(posedge clk) begin
    if (cmd.calc2) begin
      px_x <= prev_x * $signed({1'b0, prev_gap});
      cx_x <= dx * $signed({1'b0, gap});
      px_y <= prev_y * $signed({1'b0, prev_gap});
      cx_y <= dy * $signed({1'b0, gap});
      den  <= {1'b0, prev_gap} + {1'b0, gap};
    end
  end

  // Step 3: numerator magnitudes and signs
  always_ff @(posedge clk) begin
    if (cmd.calc3) begin
      num_x <= {abs_x[48:0], 8'b0};
      num_y <= {abs_y[48:0], 8'b0};
      neg_x <= sum_x[49];
      neg_y <= sum_y[49];
    end
  end

  // Persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_count <= '0;
      last_stamp  <= '0;
      prev_x      <= '0;
      prev_y      <= '0;
      prev_gap    <= '0;
    end else begin
      if (cmd.calc2 && cfg.precision_enable) begin
        if (!quiet) quiet_count <= '0;
        else if (quiet_count != QC_MAX) quiet_count <= quiet_count + 1'b1;
      end
      if (cmd.calc3) begin
        last_stamp <= stamp;
        prev_x     <= dx;
        prev_y     <= dy;
        prev_gap   <= gap;
      end
    end
  end

  // Divider operand selection
  always_comb begin
    unique case (cmd.div_sel)
      DSEL_X: begin
        div_dividend = num_x;
        div_divisor  = den;
      end
      DSEL_Y: begin
        div_dividend = num_y;
        div_divisor  = den;
      end
      default: begin
        div_dividend = DIVIDEND_W'({gain, 8'b0});
        div_divisor  = DIVISOR_W'(cfg.precision_divisor);
      end
    endcase
  end

  pmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (stat.div_busy),
    .quotient (quo)
  );

  // Gain and motion registers
  always_ff @(posedge clk) begin
    if (cmd.calc1) begin
      gain <= cfg.accel_enable ? GAIN_W'(cfg.sensitivity) : GAIN_W'({cfg.sensitivity, 2'b00});
    end else if (cmd.div_capture && cmd.div_sel == DSEL_GAIN) begin
      gain <= quo;
    end
    if (cmd.calc3) begin
      mx <= {dx[15], dx, 8'b0};
      my <= {dy[15], dy, 8'b0};
    end else if (cmd.div_capture && cmd.div_sel == DSEL_X) begin
      mx <= neg_x ? -q_mot : q_mot;
    end else if (cmd.div_capture && cmd.div_sel == DSEL_Y) begin
      my <= neg_y ? -q_mot : q_mot;
    end
  end

  // Gain multiply
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod_x <= mx * $signed({1'b0, gain});
      prod_y <= my * $signed({1'b0, gain});
    end
  end

  // Divide by 1024 toward zero, direction, saturation
  assign rnd_x   = prod_x + $signed({42'b0, {10{prod_x[51]}}});
  assign rnd_y   = prod_y + $signed({42'b0, {10{prod_y[51]}}});
  assign p_x     = rnd_x[51:10];
  assign p_y     = rnd_y[51:10];
  assign p_y_dir = cfg.invert_y ? p_y : -p_y;
  assign wh_ext  = 16'(wh);

  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      out_x     <= sat32(p_x);
      out_y     <= sat32(p_y_dir);
      out_wheel <= 16'(wh_ext * SCROLL_SCALE);
    end
  end

  // Status to the controller
  assign stat.slow   = cfg.precision_enable && (quiet_count > cfg.quiet_timeout) &&
                       (cfg.precision_divisor != '0);
  assign stat.filter = cfg.filter_enable;

endmodule

[rtl/pmc_ctrl.sv]
// ----------------------------------------------------------------------------
// pmc_ctrl
// Sequencer for one report: arithmetic steps, divider passes, output load.
// ----------------------------------------------------------------------------
module pmc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pmc_pkg::dp_stat_t stat,
  output pmc_pkg::dp_cmd_t  cmd
);
  import pmc_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b000000000001,
    ST_CALC1     = 12'b000000000010,
    ST_CALC2     = 12'b000000000100,
    ST_CALC3     = 12'b000000001000,
    ST_DIVG_GO   = 12'b000000010000,
    ST_DIVG_WAIT = 12'b000000100000,
    ST_DIVX_GO   = 12'b000001000000,
    ST_DIVX_WAIT = 12'b000010000000,
    ST_DIVY_GO   = 12'b000100000000,
    ST_DIVY_WAIT = 12'b001000000000,
    ST_MULT      = 12'b010000000000,
    ST_FIN       = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_CALC1;
      ST_CALC1:     state_next = ST_CALC2;
      ST_CALC2:     state_next = ST_CALC3;
      ST_CALC3: begin
        priority if (stat.slow) state_next = ST_DIVG_GO;
        else if (stat.filter)   state_next = ST_DIVX_GO;
        else                    state_next = ST_MULT;
      end
      ST_DIVG_GO:   state_next = ST_DIVG_WAIT;
      ST_DIVG_WAIT: if (!stat.div_busy) state_next = stat.filter ? ST_DIVX_GO : ST_MULT;
      ST_DIVX_GO:   state_next = ST_DIVX_WAIT;
      ST_DIVX_WAIT: if (!stat.div_busy) state_next = ST_DIVY_GO;
      ST_DIVY_GO:   state_next = ST_DIVY_WAIT;
      ST_DIVY_WAIT: if (!stat.div_busy) state_next = ST_MULT;
      ST_MULT:      state_next = ST_FIN;
      ST_FIN:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands
  always_comb begin
    cmd             = '0;
    cmd.div_sel     = DSEL_GAIN;
    cmd.load_in     = (state == ST_IDLE) && in_valid;
    cmd.calc1       = state == ST_CALC1;
    cmd.calc2       = state == ST_CALC2;
    cmd.calc3       = state == ST_CALC3;
    cmd.div_start   = (state == ST_DIVG_GO) || (state == ST_DIVX_GO) ||
                      (state == ST_DIVY_GO);
    if ((state == ST_DIVX_GO) || (state == ST_DIVX_WAIT)) cmd.div_sel = DSEL_X;
    if ((state == ST_DIVY_GO) || (state == ST_DIVY_WAIT)) cmd.div_sel = DSEL_Y;
    cmd.div_capture = !stat.div_busy && ((state == ST_DIVG_WAIT) ||
                      (state == ST_DIVX_WAIT) || (state == ST_DIVY_WAIT));
    cmd.mult        = state == ST_MULT;
    cmd.fin_load    = (state == ST_FIN) && out_free;
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign in_stall = state != ST_IDLE;

endmodule

[rtl/pointer_motion_conditioner.sv]
// ----------------------------------------------------------------------------
// pointer_motion_conditioner
// Pointer report conditioning: gain, precision slowdown, smoothing, Q.8 out.
// ----------------------------------------------------------------------------
// One report is taken at a time. The result register is loaded after three
// arithmetic steps, the passes of the single shared restoring divider and the
// gain multiply: one pass for the gain divide when precision slowdown applies,
// and one each for the X and Y weighted averages when filtering applies.
// The last step also waits while an earlier result is still held by a stalled
// receiver. The next report is accepted while a finished result still waits in
// the output register. Configuration is written through a separate port that
// is always ready; unknown indexes are ignored.
module pointer_motion_conditioner (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] move_x,
  input  logic signed [15:0] move_y,
  input  logic signed [7:0]  wheel,
  input  logic [31:0]        stamp_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [15:0] out_wheel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import pmc_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensitivity       <= 16'd256;
      cfg.accel_enable      <= 1'b0;
      cfg.precision_enable  <= 1'b0;
      cfg.precision_divisor <= 16'd256;
      cfg.quiet_threshold   <= 16'd0;
      cfg.quiet_timeout     <= 16'd0;
      cfg.invert_y          <= 1'b0;
      cfg.filter_enable     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SENSITIVITY: cfg.sensitivity       <= cfg_data;
        REG_ACCEL:       cfg.accel_enable      <= cfg_data[0];
        REG_PRECISION:   cfg.precision_enable  <= cfg_data[0];
        REG_PREC_DIV:    cfg.precision_divisor <= cfg_data;
        REG_QUIET_THR:   cfg.quiet_threshold   <= cfg_data;
        REG_QUIET_TMO:   cfg.quiet_timeout     <= cfg_data;
        REG_INVERT_Y:    cfg.invert_y          <= cfg_data[0];
        REG_FILTER:      cfg.filter_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pmc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .move_x    (move_x),
    .move_y    (move_y),
    .wheel     (wheel),
    .stamp_us  (stamp_us),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_wheel (out_wheel)
  );

`ifndef NO_ASSERTIONS
  // An accepted transaction keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again right after a transaction");

  // The divider is never running while the block waits for a report
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !stat.div_busy)
    else $error("divider busy while idle");

  // A result is never loaded over one that is still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_load |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  // Divider passes start only while no report can be accepted
  a_div_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> in_stall)
    else $error("divider started outside a transaction");
`endif

endmodule

[test/pointer_motion_conditioner_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pointer_motion_conditioner_tb
// Self-checking bench for the pointer motion conditioner. A scoreboard
// predicts every accepted report (gain, precision slowdown, time-weighted
// smoothing, Q.8 scaling and saturation) and compares each result
// transaction against the oldest prediction. A directed part comes first,
// then random phases under changing settings and idle/stall patterns.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [15:0] wheel;
} motion_result_t;

class motion_scoreboard;
  pmc_pkg::cfg_t      cfg;
  logic [15:0]        quiet_count;
  logic [31:0]        last_stamp;
  logic signed [15:0] prev_x;
  logic signed [15:0] prev_y;
  logic [31:0]        prev_gap;
  motion_result_t     expected_motion[$];
  int unsigned        mismatches;

  function new();
    cfg.sensitivity       = 16'd256;
    cfg.accel_enable      = 1'b0;
    cfg.precision_enable  = 1'b0;
    cfg.precision_divisor = 16'd256;
    cfg.quiet_threshold   = 16'd0;
    cfg.quiet_timeout     = 16'd0;
    cfg.invert_y          = 1'b0;
    cfg.filter_enable     = 1'b0;
    quiet_count = '0;
    last_stamp  = '0;
    prev_x      = '0;
    prev_y      = '0;
    prev_gap    = '0;
    mismatches  = 0;
  endfunction

  function void write_reg(logic [3:0] idx, logic [15:0] data);
    unique case (idx)
      pmc_pkg::REG_SENSITIVITY: cfg.sensitivity       = data;
      pmc_pkg::REG_ACCEL:       cfg.accel_enable      = data[0];
      pmc_pkg::REG_PRECISION:   cfg.precision_enable  = data[0];
      pmc_pkg::REG_PREC_DIV:    cfg.precision_divisor = data;
      pmc_pkg::REG_QUIET_THR:   cfg.quiet_threshold   = data;
      pmc_pkg::REG_QUIET_TMO:   cfg.quiet_timeout     = data;
      pmc_pkg::REG_INVERT_Y:    cfg.invert_y          = data[0];
      pmc_pkg::REG_FILTER:      cfg.filter_enable     = data[0];
      default: ;  // unmapped index: no effect
    endcase
  endfunction

  // Weighted average of previous and current motion, signed Q.8, truncated
  function longint smooth_q8(longint prev, longint cur, longint pgap, longint gap_us);
    return ((prev * pgap + cur * gap_us) * 256) / (pgap + gap_us);
  endfunction

  // Motion times Q16.10 gain back to Q.8, optional negate, saturate to 32 bits
  function logic signed [31:0] scale_q8(longint m_q8, longint gain, bit negate);
    longint p;
    p = (m_q8 * gain) / 1024;
    if (negate) p = -p;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function void predict_report(logic signed [15:0] dx, logic signed [15:0] dy,
                               logic signed [7:0] wh, logic [31:0] stamp);
    longint             gain;
    longint             mag2;
    longint             thr2;
    longint             sx;
    longint             sy;
    longint             mx;
    longint             my;
    logic [31:0]        gap;
    logic signed [15:0] wh_wide;
    motion_result_t     res;

    gain = cfg.sensitivity;
    if (!cfg.accel_enable) gain = gain * 4;

    // Precision slowdown after enough consecutive quiet reports
    if (cfg.precision_enable) begin
      mag2 = longint'(dx) * dx + longint'(dy) * dy;
      thr2 = cfg.quiet_threshold;
      thr2 = thr2 * thr2;
      if (mag2 < thr2) begin
        if (quiet_count != 16'hFFFF) quiet_count = quiet_count + 16'd1;
      end else begin
        quiet_count = '0;
      end
      if (quiet_count > cfg.quiet_timeout && cfg.precision_divisor != 0)
        gain = (gain * 256) / cfg.precision_divisor;
    end

    // Elapsed time, modulo 2^32, with a floor
    gap = stamp - last_stamp;
    if (gap < pmc_pkg::MIN_GAP_US) gap = pmc_pkg::MIN_GAP_US;
    last_stamp = stamp;

    sx = smooth_q8(prev_x, dx, prev_gap, gap);
    sy = smooth_q8(prev_y, dy, prev_gap, gap);
    prev_x   = dx;
    prev_y   = dy;
    prev_gap = gap;

    mx = cfg.filter_enable ? sx : longint'(dx) * 256;
    my = cfg.filter_enable ? sy : longint'(dy) * 256;

    wh_wide   = wh;
    res.x     = scale_q8(mx, gain, 1'b0);
    res.y     = scale_q8(my, gain, !cfg.invert_y);
    res.wheel = wh_wide * pmc_pkg::SCROLL_SCALE;
    expected_motion.push_back(res);
  endfunction

  function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [15:0] w);
    motion_result_t exp_res;
    if (expected_motion.size() == 0) begin
      $error("result transaction with no report pending: x %0d y %0d wheel %0d", x, y, w);
      mismatches++;
      return;
    end
    exp_res = expected_motion.pop_front();
    if (x !== exp_res.x) begin
      $error("out_x mismatch: expected %0d, actual %0d", exp_res.x, x);
      mismatches++;
    end
    if (y !== exp_res.y) begin
      $error("out_y mismatch: expected %0d, actual %0d", exp_res.y, y);
      mismatches++;
    end
    if (w !== exp_res.wheel) begin
      $error("out_wheel mismatch: expected %0d, actual %0d", exp_res.wheel, w);
      mismatches++;
    end
  endfunction
endclass

module pointer_motion_conditioner_tb;
  import pmc_pkg::*;

  localparam int          CLK_HIGH_NS     = 6;
  localparam int          CLK_LOW_NS      = 6;
  localparam int          RESET_CYCLES    = 6;
  localparam int          WATCHDOG_LIMIT  = 3000;
  localparam int          HOLD_OFF_CYCLES = 400;
  localparam int          DRAIN_CYCLES    = 120;
  localparam int          NUM_PHASES      = 8;
  localparam int          PHASE_REPORTS   = 230;
  localparam int          QUIET_RUN       = 40;
  localparam logic [3:0]  REG_IDX_SPARE   = 4'd8;  // first unmapped index

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic signed [15:0] move_x    = '0;
  logic signed [15:0] move_y    = '0;
  logic signed [7:0]  wheel     = '0;
  logic [31:0]        stamp_us  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [15:0] out_wheel;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_index = '0;
  logic [15:0]        cfg_data  = '0;

  motion_scoreboard motion_chk;
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               hold_left      = 0;
  int               stuck_cycles   = 0;
  logic [31:0]      stamp_clock    = '0;

  pointer_motion_conditioner u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .move_x    (move_x),
    .move_y    (move_y),
    .wheel     (wheel),
    .stamp_us  (stamp_us),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_wheel (out_wheel),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    #CLK_LOW_NS  clk = 1'b1;
    #CLK_HIGH_NS clk = 1'b0;
  end

  // Receiver: random stall, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Transaction monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) motion_chk.check_result(out_x, out_y, out_wheel);
      if (in_valid && !in_stall) motion_chk.predict_report(move_x, move_y, wheel, stamp_us);
      if (cfg_valid && cfg_ready) motion_chk.write_reg(cfg_index, cfg_data);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] advance_stamp(int unsigned delta);
    stamp_clock = stamp_clock + delta;
    return stamp_clock;
  endfunction

  function automatic logic signed [15:0] signed_upto(int unsigned lim);
    return 16'(int'($urandom_range(2 * lim)) - int'(lim));
  endfunction

  function automatic logic signed [15:0] extreme_motion();
    case ($urandom_range(4))
      0:       return 16'sh8000;
      1:       return 16'shFFFF;
      2:       return 16'sh0000;
      3:       return 16'sh0001;
      default: return 16'sh7FFF;
    endcase
  endfunction

  // Offer one report, after an optional idle gap, and wait for acceptance
  task automatic send_report(input logic signed [15:0] dx, input logic signed [15:0] dy,
                             input logic signed [7:0] wh, input logic [31:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    move_x   <= dx;
    move_y   <= dy;
    wheel    <= wh;
    stamp_us <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain_reports();
    @(negedge clk);
    in_valid <= 1'b0;
    while (motion_chk.expected_motion.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [3:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_config(input cfg_t c);
    // an unmapped index goes first; it must leave the settings alone
    cfg_write(REG_IDX_SPARE + 4'($urandom_range(7)), 16'($urandom));
    cfg_write(REG_SENSITIVITY, c.sensitivity);
    cfg_write(REG_ACCEL, 16'(c.accel_enable));
    cfg_write(REG_PRECISION, 16'(c.precision_enable));
    cfg_write(REG_PREC_DIV, c.precision_divisor);
    cfg_write(REG_QUIET_THR, c.quiet_threshold);
    cfg_write(REG_QUIET_TMO, c.quiet_timeout);
    cfg_write(REG_INVERT_Y, 16'(c.invert_y));
    cfg_write(REG_FILTER, 16'(c.filter_enable));
  endtask

  initial begin
    cfg_t               setting;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [31:0]        stamp;
    int                 run_left;
    bit                 run_quiet;
    int                 pick;
    int                 mag;

    motion_chk = new();
    run_left   = 0;
    run_quiet  = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Reset settings except filtering: first report has no history to blend
    cfg_write(REG_FILTER, 16'd1);
    send_report(16'sd1000, -16'sd2000, 8'sd5, 32'd500);
    send_report(16'sh7FFF, 16'sh8000, 8'sh7F, 32'hFFFF_FFFF);
    send_report(16'sh8000, 16'sh7FFF, 8'sh80, 32'd3);        // timestamp wrap
    send_report(16'sd0, 16'sd0, 8'sd0, 32'h8000_0000);
    stamp_clock = 32'h8000_0000;

    // Largest sensitivity, Y sign flipped back
    drain_reports();
    setting = '{sensitivity: 16'hFFFF, accel_enable: 1'b0, precision_enable: 1'b0,
                precision_divisor: 16'd256, quiet_threshold: 16'd0, quiet_timeout: 16'd0,
                invert_y: 1'b1, filter_enable: 1'b0};
    apply_config(setting);
    send_report(16'sh7FFF, 16'sh7FFF, -8'sd1, advance_stamp(1000));
    send_report(16'sh8000, 16'sh8000, 8'sh80, advance_stamp(10));
    send_report(16'sd1, -16'sd1, 8'sd1, advance_stamp(2500));

    // Divisor of one: gain grows by 256 and outputs saturate both ways
    drain_reports();
    setting.precision_enable  = 1'b1;
    setting.precision_divisor = 16'd1;
    setting.quiet_threshold   = 16'hFFFF;
    setting.invert_y          = 1'b0;
    apply_config(setting);
    send_report(16'sh7FFF, 16'sh8000, 8'sh7F, advance_stamp(4000));
    send_report(16'sh8000, 16'sh7FFF, 8'sh80, advance_stamp(999));
    send_report(16'sd0, 16'sd0, 8'sd0, advance_stamp(1001));

    // Zero divisor leaves the gain as is; tiny gain shows truncation toward zero
    drain_reports();
    setting = '{sensitivity: 16'd1, accel_enable: 1'b1, precision_enable: 1'b1,
                precision_divisor: 16'd0, quiet_threshold: 16'hFFFF, quiet_timeout: 16'd0,
                invert_y: 1'b1, filter_enable: 1'b1};
    apply_config(setting);
    send_report(16'sh8000, 16'sh7FFF, 8'sd3, advance_stamp(7000));
    send_report(-16'sd3, 16'sd5, -8'sd3, advance_stamp(300));

    // Quiet counting around the threshold and the timeout
    drain_reports();
    setting = '{sensitivity: 16'd300, accel_enable: 1'b0, precision_enable: 1'b1,
                precision_divisor: 16'd512, quiet_threshold: 16'd10, quiet_timeout: 16'd2,
                invert_y: 1'b0, filter_enable: 1'b1};
    apply_config(setting);
    send_report(16'sd3, 16'sd4, 8'sd1, advance_stamp(1200));
    send_report(-16'sd3, -16'sd4, 8'sd1, advance_stamp(1300));
    send_report(16'sd0, 16'sd0, 8'sd1, advance_stamp(1400));
    send_report(16'sd2, -16'sd5, 8'sd1, advance_stamp(1500));
    send_report(16'sd7, 16'sd8, 8'sd1, advance_stamp(1600));   // loud, count clears
    send_report(16'sd6, -16'sd7, 8'sd1, advance_stamp(1700));
    send_report(16'sd6, 16'sd8, 8'sd1, advance_stamp(1800));   // exactly on threshold
    send_report(-16'sd9, 16'sd0, 8'sd1, advance_stamp(1900));

    // Precision off: count is frozen and not applied
    drain_reports();
    setting.precision_enable = 1'b0;
    apply_config(setting);
    send_report(16'sd1, 16'sd1, -8'sd1, advance_stamp(2000));
    send_report(16'sd2, 16'sd2, -8'sd1, advance_stamp(2000));

    // Long quiet run: the largest timeout never trips, a lower one then does
    drain_reports();
    setting = '{sensitivity: 16'd256, accel_enable: 1'b0, precision_enable: 1'b1,
                precision_divisor: 16'd512, quiet_threshold: 16'hFFFF,
                quiet_timeout: 16'hFFFF, invert_y: 1'b0, filter_enable: 1'b0};
    apply_config(setting);
    for (int i = 0; i < QUIET_RUN; i++)
      send_report(signed_upto(50), signed_upto(50), 8'($urandom), advance_stamp(1000));
    drain_reports();
    cfg_write(REG_QUIET_TMO, 16'd20);
    for (int i = 0; i < 3; i++)
      send_report(signed_upto(50), signed_upto(50), 8'($urandom), advance_stamp(1000));

    // Random phases: settings, idle pattern and content change per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_reports();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      setting.sensitivity = (p == 0) ? 16'd0 : (p == 1) ? 16'hFFFF
                          : 16'($urandom_range(1024, 16));
      setting.accel_enable     = p[0];
      setting.precision_enable = !(p == 0 || p == 7);
      case (p)
        2:       setting.precision_divisor = 16'd1;
        5:       setting.precision_divisor = 16'hFFFF;
        6:       setting.precision_divisor = 16'd0;
        default: setting.precision_divisor = 16'($urandom_range(1024, 64));
      endcase
      setting.quiet_threshold = (p == 3) ? 16'hFFFF : (p == 1) ? 16'd0
                              : 16'($urandom_range(600));
      setting.quiet_timeout   = (p == 4) ? 16'hFFFF : (p == 2) ? 16'd0
                              : 16'($urandom_range(20));
      setting.invert_y        = p[1];
      setting.filter_enable   = (p % 4 == 1) || (p % 4 == 2);
      apply_config(setting);

      case (p % 4)
        1:       send_idle_pct = 88;
        2:       recv_stall_pct = 88;
        3:       begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
        end
        default: ;
      endcase
      // long receiver hold-off while reports keep coming: the block backs up
      if (p == 0) hold_left = HOLD_OFF_CYCLES;

      for (int n = 0; n < PHASE_REPORTS; n++) begin
        if (run_left == 0) begin
          run_quiet = ($urandom_range(99) < 70);
          run_left  = run_quiet ? $urandom_range(40, 3) : $urandom_range(6, 1);
        end
        run_left--;
        pick = $urandom_range(99);
        if (run_quiet) begin
          // half the threshold per axis keeps dx^2 + dy^2 below a nonzero threshold^2
          dx = signed_upto(setting.quiet_threshold / 2);
          dy = signed_upto(setting.quiet_threshold / 2);
        end else if (pick < 40) begin
          dx = 16'($urandom);
          dy = 16'($urandom);
        end else if (pick < 75) begin
          mag = int'(setting.quiet_threshold) + int'($urandom_range(2)) - 1;
          dx  = (mag > 32767) ? 16'sh7FFF : 16'(mag);
          dy  = signed_upto(1);
          if ($urandom_range(1)) begin
            dy = dx;
            dx = signed_upto(1);
          end
        end else begin
          dx = extreme_motion();
          dy = extreme_motion();
        end

        pick = $urandom_range(99);
        if (pick < 80)      stamp = advance_stamp($urandom_range(20000));
        else if (pick < 90) stamp = advance_stamp($urandom_range(999));
        else if (pick < 95) begin
          stamp_clock = $urandom;
          stamp = stamp_clock;
        end else stamp = advance_stamp($urandom_range(32'hFFFF_FFFF, 32'h8000_0000));

        send_report(dx, dy, 8'($urandom), stamp);
        // now and then the sender waits for the pipeline to empty
        if ($urandom_range(99) == 0) drain_reports();
      end
    end

    drain_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (motion_chk.expected_motion.size() != 0) begin
      $error("%0d predicted results never arrived", motion_chk.expected_motion.size());
      motion_chk.mismatches++;
    end
    if (motion_chk.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
